FILE: src/gic_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the generalized index convolution block.
// No dependencies; imported by gic_idx, generalized_index_convolution and the testbench.
package gic_pkg;

   localparam int MAX_LEN = 64;
   localparam int ADDR_W  = 6;     // index into a vector of MAX_LEN entries
   localparam int CNT_W   = 7;     // can hold MAX_LEN itself
   localparam int DATA_W  = 32;
   localparam int KEY_W   = 13;    // widest combined index (64 * 64)

   // Index rules
   localparam logic [3:0] MODE_SUM   = 4'd0;
   localparam logic [3:0] MODE_DIFF  = 4'd1;
   localparam logic [3:0] MODE_PROD  = 4'd2;
   localparam logic [3:0] MODE_EXACT = 4'd3;
   localparam logic [3:0] MODE_FLOOR = 4'd4;
   localparam logic [3:0] MODE_AND   = 4'd5;
   localparam logic [3:0] MODE_OR    = 4'd6;
   localparam logic [3:0] MODE_XOR   = 4'd7;
   localparam logic [3:0] MODE_MIN   = 4'd8;
   localparam logic [3:0] MODE_MAX   = 4'd9;

   // Register indexes
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;

   // One (i, j) pair from the index sequencer
   typedef struct packed {
      logic [ADDR_W-1:0] ci;     // zero-based i, read address of first vector
      logic [ADDR_W-1:0] cj;     // zero-based j, read address of second vector
      logic              hit;    // combined index lies in 1..n
      logic [ADDR_W-1:0] slot;   // combined index minus one
      logic              last;   // final pair of the set
   } pair_type;

endpackage

FILE: src/gic_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: src/gic_idx.sv
`timescale 1ns / 1ps
// Pair sequencer: walks all (i, j) pairs and forms the combined index.
// Depends on gic_pkg.
module gic_idx import gic_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              advance,
   input  logic [3:0]        mode,
   input  logic [ADDR_W-1:0] nm1,
   output pair_type          pair
);

   logic [ADDR_W-1:0] ci_ff, ci_in, cj_ff, cj_in;
   logic [CNT_W-1:0]  q_ff, q_in, r_ff, r_in;   // i / j and i % j, kept incrementally
   logic [CNT_W-1:0]  i_val, j_val, n_val;
   logic [KEY_W-1:0]  k;

   assign i_val = {1'b0, ci_ff} + CNT_W'(1);
   assign j_val = {1'b0, cj_ff} + CNT_W'(1);
   assign n_val = {1'b0, nm1} + CNT_W'(1);

   // Inner loop over i, outer over j; quotient and remainder follow i
   always_comb begin
      ci_in = ci_ff;
      cj_in = cj_ff;
      q_in  = q_ff;
      r_in  = r_ff;
      if (start) begin
         ci_in = '0;
         cj_in = '0;
         q_in  = CNT_W'(1);
         r_in  = '0;
      end else if (advance) begin
         if (ci_ff == nm1) begin
            ci_in = '0;
            cj_in = cj_ff + ADDR_W'(1);
            q_in  = '0;              // next j is at least 2, so 1 / j is 0
            r_in  = CNT_W'(1);
         end else begin
            ci_in = ci_ff + ADDR_W'(1);
            if (r_ff + CNT_W'(1) == j_val) begin
               q_in = q_ff + CNT_W'(1);
               r_in = '0;
            end else begin
               r_in = r_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff <= '0;
         cj_ff <= '0;
         q_ff  <= CNT_W'(1);
         r_ff  <= '0;
      end else begin
         ci_ff <= ci_in;
         cj_ff <= cj_in;
         q_ff  <= q_in;
         r_ff  <= r_in;
      end
   end

   // Combined index; zero means no contribution
   always_comb begin
      case (mode)
         MODE_SUM:   k = KEY_W'(i_val) + KEY_W'(j_val);
         MODE_DIFF:  k = (i_val > j_val) ? KEY_W'(i_val - j_val) : '0;
         MODE_PROD:  k = KEY_W'(i_val) * KEY_W'(j_val);
         MODE_EXACT: k = (r_ff == '0) ? KEY_W'(q_ff) : '0;
         MODE_FLOOR: k = KEY_W'(q_ff);
         MODE_AND:   k = KEY_W'(i_val & j_val);
         MODE_OR:    k = KEY_W'(i_val | j_val);
         MODE_XOR:   k = KEY_W'(i_val ^ j_val);
         MODE_MIN:   k = (i_val < j_val) ? KEY_W'(i_val) : KEY_W'(j_val);
         MODE_MAX:   k = (i_val > j_val) ? KEY_W'(i_val) : KEY_W'(j_val);
         default:    k = '0;
      endcase
   end

   always_comb begin
      pair.ci   = ci_ff;
      pair.cj   = cj_ff;
      pair.hit  = (k != '0) && (k <= KEY_W'(n_val));
      pair.slot = ADDR_W'(k - KEY_W'(1));
      pair.last = (ci_ff == nm1) && (cj_ff == nm1);
   end

endmodule

FILE: src/generalized_index_convolution.sv
`timescale 1ns / 1ps
// Generalized index convolution: loads n (a, b) pairs, then forms c[k] as the sum of
// a[i]*b[j] over all pairs whose combined index under the chosen rule equals k, and
// returns c[1..n]. The request completing a set is followed by a sweep clearing the
// accumulator memory, a multiply-accumulate pass over all n*n pairs (one pair per cycle
// through a three-stage read-modify-write loop on the accumulator memory, with
// forwarding), a drain, and then each result through the ORD, OWAIT and OHOLD states
// plus any output stall. The n*n pass bounds throughput.
// Requests are taken only between sets.
// Depends on gic_pkg, gic_ram and gic_idx.
module generalized_index_convolution import gic_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [CNT_W-1:0]   csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_a_value,
   input  logic signed [31:0] req_b_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [5:0]         rsp_result_index,
   output logic               rsp_last_result
);

   typedef enum logic [2:0] {
      IDLE, CLEAR, RUN, DRAIN, ORD, OWAIT, OHOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        mode_ff;
   logic [CNT_W-1:0]  len_ff, lc_ff, lc_in;
   logic [ADDR_W-1:0] nm1_ff, nm1_in, idx_ff, idx_in;
   logic              drain_ff, drain_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ADDR_W-1:0] rsp_index_ff, rsp_index_in;

   logic [CNT_W-1:0]  n_eff;
   logic [ADDR_W-1:0] pos;
   logic              req_fire, start;
   pair_type          pair;

   logic [DATA_W-1:0] a_rd, b_rd, acc_rd, sum, acc_wdata;
   logic [ADDR_W-1:0] acc_waddr, acc_raddr;
   logic              acc_we;

   // multiply-accumulate pipeline
   logic              s1_v_ff, s2_v_ff, s3_v_ff;
   logic [ADDR_W-1:0] s1_slot_ff, s2_slot_ff, s3_slot_ff;
   logic [DATA_W-1:0] s2_prod_ff, s3_sum_ff, prod;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SUM;
         len_ff  <= CNT_W'(MAX_LEN);
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:   mode_ff <= csr_write_data[3:0];
            REG_LENGTH: len_ff  <= csr_write_data;
            default:    ;
         endcase
      end
   end

   assign n_eff = (len_ff == '0) ? CNT_W'(1) :
                  (len_ff > CNT_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : len_ff;
   assign pos   = (lc_ff >= CNT_W'(MAX_LEN)) ? ADDR_W'(MAX_LEN - 1) : lc_ff[ADDR_W-1:0];

   assign req_ready = (state_ff == IDLE);
   assign req_fire  = req_valid && req_ready;
   assign start     = req_fire && ({1'b0, pos} + CNT_W'(1) >= n_eff);

   // vector stores
   gic_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_first_store (
      .clock(clock), .we(req_fire), .waddr(pos), .wdata(req_a_value),
      .raddr(pair.ci), .rdata(a_rd)
   );
   gic_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_second_store (
      .clock(clock), .we(req_fire), .waddr(pos), .wdata(req_b_value),
      .raddr(pair.cj), .rdata(b_rd)
   );

   gic_idx u_idx (
      .clock(clock), .reset(reset), .start(start), .advance(state_ff == RUN),
      .mode(mode_ff), .nm1(nm1_ff), .pair(pair)
   );

   // accumulator memory: clear sweep or pipeline write-back; read for pipeline or output
   assign prod      = a_rd * b_rd;
   assign sum       = ((s3_v_ff && s3_slot_ff == s2_slot_ff) ? s3_sum_ff : acc_rd) + s2_prod_ff;
   assign acc_we    = (state_ff == CLEAR) || s2_v_ff;
   assign acc_waddr = (state_ff == CLEAR) ? idx_ff : s2_slot_ff;
   assign acc_wdata = (state_ff == CLEAR) ? '0 : sum;
   assign acc_raddr = (state_ff == ORD) ? idx_ff : s1_slot_ff;

   gic_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_accumulators (
      .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
      .raddr(acc_raddr), .rdata(acc_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= (state_ff == RUN) && pair.hit;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
      s1_slot_ff <= pair.slot;
      s2_slot_ff <= s1_slot_ff;
      s2_prod_ff <= prod;
      s3_slot_ff <= s2_slot_ff;
      s3_sum_ff  <= sum;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      lc_in        = lc_ff;
      nm1_in       = nm1_ff;
      idx_in       = idx_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               lc_in    = '0;
               nm1_in   = ADDR_W'(n_eff - CNT_W'(1));
               idx_in   = '0;
               state_in = CLEAR;
            end else if (req_fire) begin
               lc_in = {1'b0, pos} + CNT_W'(1);
            end
         end
         CLEAR: begin
            idx_in = idx_ff + ADDR_W'(1);
            if (idx_ff == nm1_ff) begin
               state_in = RUN;
            end
         end
         RUN: begin
            if (pair.last) begin
               drain_in = 1'b0;
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               idx_in   = '0;
               state_in = ORD;
            end
         end
         ORD: begin
            state_in = OWAIT;
         end
         OWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = acc_rd;
            rsp_index_in = idx_ff;
            rsp_last_in  = (idx_ff == nm1_ff);
            state_in     = OHOLD;
         end
         OHOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + ADDR_W'(1);
               state_in     = rsp_last_ff ? IDLE : ORD;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nm1_ff       <= nm1_in;
      idx_ff       <= idx_in;
      drain_ff     <= drain_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last_result  = rsp_last_ff;

`ifndef SYNTHESIS
   a_clear_no_writeback: assert property (@(posedge clock) disable iff (reset)
      state_ff == CLEAR |-> !s2_v_ff)
      else $error("accumulator clear overlaps a write-back");
   a_rsp_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == OHOLD)
      else $error("result shown outside output hold");
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_index_ff == nm1_ff)
      else $error("last flag on wrong index");
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      lc_ff <= CNT_W'(MAX_LEN))
      else $error("load count beyond vector length");
   a_pipe_empty_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ORD |-> !s1_v_ff && !s2_v_ff)
      else $error("result read while pipeline busy");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for generalized_index_convolution: directed table, then random sets of
// pairs under every index rule, checked against an in-bench convolution predictor.
// Depends on gic_pkg and the generalized_index_convolution RTL.
module tb_top;
   import gic_pkg::*;

   localparam int LIMIT  = 20000000;
   localparam int NITEMS = 410;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [CNT_W-1:0]   csr_write_data;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_a_value;
   logic signed [31:0] req_b_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_result_value;
   logic [5:0]         rsp_result_index;
   logic               rsp_last_result;

   generalized_index_convolution dut (.*);

   // one expected result element
   typedef struct {
      bit [31:0] value;
      bit [5:0]  index;
      bit        last;
   } coef_type;

   // one row of the directed table: a register write or a request
   typedef struct {
      bit        is_csr;
      bit [1:0]  idx;
      bit [6:0]  data;
      bit [31:0] a;
      bit [31:0] b;
      bit        known;
      bit [31:0] kval;
   } plan_row_type;

   coef_type  coef_queue[$];
   bit [3:0]  rule_q;
   bit [6:0]  len_q;
   bit [31:0] a_mem[MAX_LEN];
   bit [31:0] b_mem[MAX_LEN];
   int unsigned fill;
   int unsigned sent;
   int unsigned bad;
   int unsigned cycles;

   // directed table: extremes on n = 1, zero length clamped to one, ignored indexes,
   // unused rule, every rule on n = 2, length lowered during a load
   plan_row_type plan[$] = '{
      '{1, REG_LENGTH, 7'd1,  0, 0, 0, 0},
      '{1, REG_MODE,   7'h78, 0, 0, 0, 0},
      '{0, 0, 0, 32'h7fffffff, 32'h7fffffff, 1, 32'h00000001},
      '{0, 0, 0, 32'h80000000, 32'h80000000, 1, 32'h00000000},
      '{0, 0, 0, 32'h80000000, 32'h7fffffff, 1, 32'h80000000},
      '{1, REG_MODE,   {3'd0, MODE_SUM}, 0, 0, 0, 0},
      '{0, 0, 0, 32'hffffffff, 32'hffffffff, 1, 32'h00000000},
      '{1, REG_LENGTH, 7'd0,  0, 0, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_MAX}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd3, 32'd4, 1, 32'd12},
      '{1, 2'd2, 7'd5,   0, 0, 0, 0},
      '{1, 2'd3, 7'h7f,  0, 0, 0, 0},
      '{0, 0, 0, 32'd2, 32'd3, 1, 32'd6},
      '{1, REG_MODE,   7'd12, 0, 0, 0, 0},
      '{0, 0, 0, 32'd5, 32'd5, 1, 32'd0},
      '{1, REG_LENGTH, 7'd2,  0, 0, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_SUM}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd1, 32'd2, 0, 0},  '{0, 0, 0, 32'd3, 32'd4, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_DIFF}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd5, 32'hfffffffa, 0, 0}, '{0, 0, 0, 32'd7, 32'd8, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_PROD}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd9, 32'd10, 0, 0}, '{0, 0, 0, 32'd11, 32'd12, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_EXACT}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd13, 32'd14, 0, 0}, '{0, 0, 0, 32'd15, 32'hfffffff0, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_FLOOR}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd17, 32'd18, 0, 0}, '{0, 0, 0, 32'd19, 32'd20, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_AND}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd21, 32'd22, 0, 0}, '{0, 0, 0, 32'd23, 32'd24, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_OR}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd25, 32'd26, 0, 0}, '{0, 0, 0, 32'd27, 32'd28, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_XOR}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd29, 32'd30, 0, 0}, '{0, 0, 0, 32'd31, 32'd32, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_MIN}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd33, 32'd34, 0, 0}, '{0, 0, 0, 32'd35, 32'd36, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_MAX}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd37, 32'd38, 0, 0}, '{0, 0, 0, 32'd39, 32'd40, 0, 0},
      '{1, REG_LENGTH, 7'd4,  0, 0, 0, 0},
      '{1, REG_MODE,   {3'd0, MODE_PROD}, 0, 0, 0, 0},
      '{0, 0, 0, 32'd2, 32'd3, 0, 0},  '{0, 0, 0, 32'd4, 32'd5, 0, 0},
      '{0, 0, 0, 32'd6, 32'd7, 0, 0},
      '{1, REG_LENGTH, 7'd2,  0, 0, 0, 0},
      '{0, 0, 0, 32'd8, 32'd9, 0, 0}
   };

   // combined index of (i, j) under rule r; 0 means the pair is dropped
   function automatic int unsigned combine_idx(bit [3:0] r, int unsigned i, int unsigned j);
      case (r)
         MODE_SUM:   return i + j;
         MODE_DIFF:  return (i > j) ? i - j : 0;
         MODE_PROD:  return i * j;
         MODE_EXACT: return (i % j == 0) ? i / j : 0;
         MODE_FLOOR: return i / j;
         MODE_AND:   return i & j;
         MODE_OR:    return i | j;
         MODE_XOR:   return i ^ j;
         MODE_MIN:   return (i < j) ? i : j;
         MODE_MAX:   return (i > j) ? i : j;
         default:    return 0;
      endcase
   endfunction

   function automatic int unsigned eff_len();
      if (len_q == 0) return 1;
      if (len_q > MAX_LEN) return MAX_LEN;
      return len_q;
   endfunction

   // store one accepted pair; when the set completes, queue the n coefficients
   function automatic void convolve_pair(bit [31:0] a, bit [31:0] b, bit known,
                                         bit [31:0] kval);
      int unsigned n;
      int unsigned pos;
      int unsigned k;
      bit [31:0]   c[MAX_LEN];
      coef_type    e;
      n   = eff_len();
      pos = (fill > MAX_LEN - 1) ? MAX_LEN - 1 : fill;
      a_mem[pos] = a;
      b_mem[pos] = b;
      fill = pos + 1;
      if (fill < n) return;
      fill = 0;
      foreach (c[x]) c[x] = '0;
      for (int i = 1; i <= n; i++)
         for (int j = 1; j <= n; j++) begin
            k = combine_idx(rule_q, i, j);
            if (k >= 1 && k <= n) c[k-1] += a_mem[i-1] * b_mem[j-1];
         end
      for (int x = 0; x < n; x++) begin
         e.value = known ? kval : c[x];
         e.index = x[5:0];
         e.last  = (x + 1 == n);
         coef_queue = {coef_queue, e};
      end
   endfunction

   function automatic bit [31:0] pick_word();
      case ($urandom % 8)
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'hffffffff;
         3: return $urandom_range(0, 1);
         4, 5: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // clock and timeout
   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // offer one request and hold it until taken, then an optional gap
   task automatic send_pair(bit [31:0] a, bit [31:0] b, bit known, bit [31:0] kval);
      int unsigned gap;
      int unsigned r;
      req_valid   <= 1'b1;
      req_a_value <= a;
      req_b_value <= b;
      do @(posedge clock); while (!req_ready);
      convolve_pair(a, b, known, kval);
      sent++;
      r = $urandom % 10;
      gap = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid and wait until every queued coefficient has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (coef_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(bit [1:0] idx, bit [6:0] data);
      csr_we         <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      if (idx == REG_MODE) rule_q = data[3:0];
      else if (idx == REG_LENGTH) len_q = data;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off, and the result check
   int unsigned stall;
   int unsigned seen;
   bit          held;
   coef_type    exp_c;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (coef_queue.size() == 0) begin
               bad++;
               if (bad <= 10) $display("unexpected result value %h index %0d",
                                        rsp_result_value, rsp_result_index);
            end else begin
               exp_c = coef_queue.pop_front();
               if (rsp_result_value !== exp_c.value || rsp_result_index !== exp_c.index ||
                   rsp_last_result !== exp_c.last) begin
                  bad++;
                  if (bad <= 10)
                     $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b", exp_c.value,
                              exp_c.index, exp_c.last, rsp_result_value,
                              rsp_result_index, rsp_last_result);
               end
            end
         end
         if (!held && seen >= 80) begin
            held = 1'b1;
            stall = 800;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom % 4 == 0)
               stall = ($urandom % 10 == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
         end
      end
   end

   // stimulus
   initial begin
      int unsigned n;
      int cut;
      int cnt;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_a_value    = '0;
      req_b_value    = '0;
      rule_q         = MODE_SUM;
      len_q          = 7'd64;
      fill           = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (plan[p]) begin
         if (plan[p].is_csr) begin
            settle();
            csr_write(plan[p].idx, plan[p].data);
         end else begin
            send_pair(plan[p].a, plan[p].b, plan[p].known, plan[p].kval);
         end
      end

      // random phases: new rule and length, then one to three sets
      while (sent < NITEMS) begin
         settle();
         csr_write(REG_MODE, {3'($urandom_range(0, 7)),
                   ($urandom % 8 == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9))});
         case ($urandom % 16)
            0:       csr_write(REG_LENGTH, 7'd64);
            1:       csr_write(REG_LENGTH, 7'($urandom_range(65, 127)));
            2:       csr_write(REG_LENGTH, 7'd0);
            default: csr_write(REG_LENGTH, 7'($urandom_range(1, 10)));
         endcase
         repeat ($urandom_range(1, 3)) begin
            n   = eff_len();
            cut = (n > 1 && $urandom % 5 == 0) ? int'($urandom_range(1, n - 1)) : -1;
            cnt = 0;
            // length may change part way through a load
            do begin
               if (cnt == cut) begin
                  settle();
                  csr_write(REG_LENGTH, 7'($urandom_range(0, 10)));
               end
               send_pair(pick_word(), pick_word(), 1'b0, '0);
               cnt++;
            end while (fill != 0);
         end
      end

      settle();
      repeat (50) @(posedge clock);
      if (bad == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule

FILE: files.f
src/gic_pkg.sv
src/gic_ram.sv
src/gic_idx.sv
src/generalized_index_convolution.sv
sim/tb_top.sv
